/* src/csd_pkg.sv */
// shared types, constants and digit helpers for the seven-segment serial driver
`default_nettype none
package csd_pkg;

	localparam int FRAME_BYTES = 6;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;
	localparam int CNT_W       = $clog2(FRAME_BITS + 1);

	// frame request selectors
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_ALL_OFF = 2'd1;
	localparam logic [1:0] OP_ALL_ON  = 2'd2;
	localparam logic [1:0] OP_PATTERN = 2'd3;

	// fill bytes for the test frames
	localparam logic [7:0] FILL_OFF     = 8'h00;
	localparam logic [7:0] FILL_ON      = 8'hff;
	localparam logic [7:0] FILL_PATTERN = 8'h55;
	localparam logic [7:0] BLANK_BYTE   = 8'h00;

	localparam int COLON_POS = 7;

	// one queued frame: serial bits, byte 0 in the top byte, plus latch flags
	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		logic                  remote_req;
		logic                  local_req;
	} frame_t;

	// segment code of a decimal digit, blank for codes above nine
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0:    c = 8'h3f;
			4'd1:    c = 8'h06;
			4'd2:    c = 8'h5b;
			4'd3:    c = 8'h4f;
			4'd4:    c = 8'h66;
			4'd5:    c = 8'h6d;
			4'd6:    c = 8'h7d;
			4'd7:    c = 8'h07;
			4'd8:    c = 8'h7f;
			4'd9:    c = 8'h6f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// tens digit of a six-bit value, at most six
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	// ones digit given the tens digit
	function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
		logic [5:0] tx10;
		logic [5:0] r;
		tx10 = {t, 3'b000} + {2'b00, t, 1'b0};
		r    = v - tx10;
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

/* src/csd_if.sv */
// channel interfaces: frame requests, serial results and configuration writes
`default_nettype none
interface csd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;
	logic       link_up;
	logic       remote_synced;

	modport source (output valid, op, hours, minutes, seconds, link_up, remote_synced,
		input ready);
	modport sink (input valid, op, hours, minutes, seconds, link_up, remote_synced,
		output ready);
endinterface

interface csd_res_if;
	logic valid;
	logic ready;
	logic serial_data;
	logic latch_pulse;
	logic remote_sync_request;
	logic local_sync_request;

	modport source (output valid, serial_data, latch_pulse, remote_sync_request,
		local_sync_request, input ready);
	modport sink (input valid, serial_data, latch_pulse, remote_sync_request,
		local_sync_request, output ready);
endinterface

interface csd_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* src/csd_front.sv */
// front end: takes frame requests, builds the 48-bit frame and sync flags
`default_nettype none
module csd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	csd_req_if.sink            req,
	csd_cfg_if.sink            cfg,
	input  wire logic          q_full,
	output csd_pkg::frame_t    push_data,
	output logic               push
);
	import csd_pkg::*;

	logic       seconds_hidden_q;
	logic       tick_parity_q;
	logic       parity_next;
	logic       is_tick;
	logic [2:0] h_t;
	logic [3:0] h_o;
	logic [2:0] m_t;
	logic [3:0] m_o;
	logic [2:0] s_t;
	logic [3:0] s_o;
	logic [7:0] b0, b1, b2, b3, b4, b5;
	logic [7:0] fill;

	assign cfg.ready = 1'b1;
	assign req.ready = !q_full;
	assign push      = req.valid && req.ready;
	assign is_tick   = (req.op == OP_TICK);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_hidden_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			seconds_hidden_q <= cfg.data;
		end
	end

	// tick parity flips on each accepted clock tick
	assign parity_next = tick_parity_q ^ is_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_parity_q <= 1'b0;
		end else if (push) begin
			tick_parity_q <= parity_next;
		end
	end

	// digit split
	always_comb begin
		h_t = tens_of({1'b0, req.hours});
		h_o = ones_of({1'b0, req.hours}, h_t);
		m_t = tens_of(req.minutes);
		m_o = ones_of(req.minutes, m_t);
		s_t = tens_of(req.seconds);
		s_o = ones_of(req.seconds, s_t);
	end

	// frame assembly
	always_comb begin
		case (req.op)
			OP_ALL_OFF: fill = FILL_OFF;
			OP_ALL_ON:  fill = FILL_ON;
			OP_PATTERN: fill = FILL_PATTERN;
			default:    fill = FILL_OFF;
		endcase
		b0 = fill;
		b1 = fill;
		b2 = fill;
		b3 = fill;
		b4 = fill;
		b5 = fill;
		push_data.remote_req = 1'b0;
		push_data.local_req  = 1'b0;
		if (is_tick) begin
			b0 = seg_code({1'b0, h_t});
			b1 = seg_code(h_o);
			b2 = seg_code({1'b0, m_t});
			b3 = seg_code(m_o);
			if (!seconds_hidden_q) begin
				b4 = seg_code(s_o);
				b5 = seg_code({1'b0, s_t});
				b2[COLON_POS] = 1'b1;
			end else begin
				b4 = BLANK_BYTE;
				b5 = BLANK_BYTE;
				b2[COLON_POS] = !parity_next;
			end
			push_data.remote_req = (s_o == 4'd0) && req.link_up && !req.remote_synced;
			push_data.local_req  = !req.seconds[0] && req.link_up;
		end
		push_data.bits = {b0, b1, b2, b3, b4, b5};
	end

endmodule
`default_nettype wire

/* src/csd_queue.sv */
// short frame queue between front and back ends
`default_nettype none
module csd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire csd_pkg::frame_t  push_data,
	input  wire logic             pop,
	output csd_pkg::frame_t       pop_data,
	output logic                  full,
	output logic                  empty
);
	import csd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	frame_t          entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/csd_back.sv */
// back end: shifts a frame out MSB first, then the latch beat
`default_nettype none
module csd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire csd_pkg::frame_t  q_data,
	output logic                  pop,
	csd_res_if.source             res
);
	import csd_pkg::*;

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BITS);

	logic [FRAME_BITS-1:0] shift_q;
	logic                  remote_q;
	logic                  local_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  active_q;
	logic                  out_valid_q;
	logic                  serial_q;
	logic                  latch_q;
	logic                  remote_out_q;
	logic                  local_out_q;
	logic                  adv;
	logic                  last;

	assign adv  = !out_valid_q || res.ready;
	assign last = active_q && (idx_q == LAST_IDX);
	assign pop  = adv && (!active_q || last) && !q_empty;

	assign res.valid               = out_valid_q;
	assign res.serial_data         = serial_q;
	assign res.latch_pulse         = latch_q;
	assign res.remote_sync_request = remote_out_q;
	assign res.local_sync_request  = local_out_q;

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// frame shifter and output beat register
	always_ff @(posedge clk) begin
		if (adv) begin
			if (active_q) begin
				serial_q     <= last ? 1'b1 : shift_q[FRAME_BITS-1];
				latch_q      <= last;
				remote_out_q <= last && remote_q;
				local_out_q  <= last && local_q;
			end
			if (pop) begin
				shift_q  <= q_data.bits;
				remote_q <= q_data.remote_req;
				local_q  <= q_data.local_req;
			end else if (active_q) begin
				shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

/* src/clock_seven_segment_serial_driver_unit.sv */
// top level of the seven-segment clock serial driver
//
// req carries one frame request per beat: a clock tick with the time, or a
// fixed fill frame (all off, all on, 0x55 pattern). Each request yields 49
// beats on res: 48 data bits, byte 0 first, MSB first, then one latch beat
// with serial_data high and latch_pulse set. On the latch beat of a clock
// tick the remote and local time-sync request flags are valid.
// cfg writes seconds_hidden; it is always ready and should be written only
// while no frame is in flight.
// The front end builds the frame in the cycle the request is taken and puts
// it in a short queue; the back end shifter emits one beat per cycle while res
// is ready, so frames follow back to back. An idle request's frame passes
// through the queue and the shift register before its first data beat is
// registered on res. req stays ready while the queue has room, so up to
// QUEUE_DEPTH frames may wait while the shifter is busy. A stall on res
// freezes the shifter and the held beat; nothing is lost. Reset empties the
// queue, clears the tick parity and seconds_hidden, and drops res.valid.
`default_nettype none
module clock_seven_segment_serial_driver_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	csd_req_if.sink    req,
	csd_res_if.source  res,
	csd_cfg_if.sink    cfg
);
	import csd_pkg::*;

	frame_t push_data;
	frame_t pop_data;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;

	csd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.q_full    (q_full),
		.push_data (push_data),
		.push      (push)
	);

	csd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	csd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.res     (res)
	);

endmodule
`default_nettype wire
